// ===== rtl/triangle_rasterizer_macros.svh =====
// assertion macros for the triangle rasterizer
`ifndef TRIANGLE_RASTERIZER_MACROS_SVH
`define TRIANGLE_RASTERIZER_MACROS_SVH
`ifndef SYNTH
`define TR_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define TR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define TR_ASSERT_IMP(label, clk, rst, a, c)
`define TR_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/trirast_pkg.sv =====
// package of the triangle rasterizer: types and constants
package trirast_pkg;
   localparam int COORD_INT_BITS_DEF  = 12;
   localparam int COORD_FRAC_BITS_DEF = 4;
   localparam int PIX_W   = 12;
   localparam int FRAME_W = 13;
   localparam int COLOR_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam logic [FRAME_W-1:0] FRAME_MAX = 13'd4096;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_MESH_COLOR   = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOX,
      ST_AREA,
      ST_SCAN,
      ST_MUL,
      ST_TEST,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;     // capture vertices
      logic box;      // compute clamped box
      logic area;     // compute area
      logic start;    // start scan
      logic mul;      // first products
      logic test;     // coverage sums
      logic step;     // advance scan position
   } cmd_type;

   typedef struct packed {
      logic box_ok;
      logic area_ok;
      logic last;
   } status_type;
endpackage

// ===== rtl/trirast_ctrl.sv =====
// controller state machine of the triangle rasterizer
`include "triangle_rasterizer_macros.svh"
module trirast_ctrl import trirast_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;
   logic active_ff, active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_kind) begin
                  cmd.load  = 1'b1;
                  active_in = 1'b0;
                  state_in  = ST_BOX;
               end else if (active_ff) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_BOX: begin
            cmd.box  = 1'b1;
            state_in = ST_AREA;
         end
         ST_AREA: begin
            cmd.area = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.box_ok && status.area_ok) begin
               cmd.start = 1'b1;
               active_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.step = 1'b1;
               if (status.last) active_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `TR_ASSERT_IMP(a_rsp_only_active, clock, reset, rsp_valid, active_ff)
   `TR_ASSERT_NEXT(a_last_drops, clock, reset, rsp_valid && rsp_ready && status.last, !active_ff)
   `TR_ASSERT_NEXT(a_load_clears, clock, reset, cmd.load, !active_ff)
endmodule

// ===== rtl/trirast_datapath.sv =====
// datapath of the triangle rasterizer: vertices, box, edge products, scan
module trirast_datapath import trirast_pkg::*; #(
   parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [15:0] req_ax,
   input  logic signed [15:0] req_ay,
   input  logic signed [15:0] req_bx,
   input  logic signed [15:0] req_by_coord,
   input  logic signed [15:0] req_cx,
   input  logic signed [15:0] req_cy,
   input  logic [FRAME_W-1:0] frame_width,
   input  logic [FRAME_W-1:0] frame_height,
   output logic [PIX_W-1:0]   rsp_pixel_x,
   output logic [PIX_W-1:0]   rsp_pixel_y,
   output logic               rsp_covered,
   output logic               rsp_last_pixel
);
   localparam int CW = COORD_INT_BITS + COORD_FRAC_BITS;
   localparam int DW = CW + 2;            // edge and pixel deltas
   localparam int PW = 2 * DW;            // products
   localparam int SW = PW + 2;            // sums

   logic signed [CW-1:0] vx_ff [3];
   logic signed [CW-1:0] vy_ff [3];
   logic signed [CW-1:0] vx_in [3];
   logic signed [CW-1:0] vy_in [3];
   logic signed [DW-1:0] e1x, e1y, e2x, e2y, px, py;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [SW-1:0] d_ff, nv, nw, nu;
   logic [PIX_W-1:0] minx_ff, miny_ff, maxx_ff, maxy_ff, sx_ff, sy_ff;
   logic box_ok_ff, cov_ff;
   logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [CW:0] tlx, thx, tly, thy;
   logic signed [14:0] lim_w, lim_h;
   logic signed [CW:0] clx, chx, cly, chy;
   logic [FRAME_W-1:0] wc, hc;

   always_comb begin
      vx_in[0] = req_ax[CW-1:0];
      vy_in[0] = req_ay[CW-1:0];
      vx_in[1] = req_bx[CW-1:0];
      vy_in[1] = req_by_coord[CW-1:0];
      vx_in[2] = req_cx[CW-1:0];
      vy_in[2] = req_cy[CW-1:0];
   end

   function automatic logic signed [CW:0] trunc_fix(input logic signed [CW-1:0] v);
      logic signed [CW:0] a;
      a = (v < 0) ? -{v[CW-1], v} : {v[CW-1], v};
      a = a >>> COORD_FRAC_BITS;
      return (v < 0) ? -a : a;
   endfunction

   always_comb begin
      lo_x = vx_ff[0]; hi_x = vx_ff[0]; lo_y = vy_ff[0]; hi_y = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < lo_x) lo_x = vx_ff[i];
         if (vx_ff[i] > hi_x) hi_x = vx_ff[i];
         if (vy_ff[i] < lo_y) lo_y = vy_ff[i];
         if (vy_ff[i] > hi_y) hi_y = vy_ff[i];
      end
      tlx = trunc_fix(lo_x); thx = trunc_fix(hi_x);
      tly = trunc_fix(lo_y); thy = trunc_fix(hi_y);
      wc = (frame_width  > FRAME_MAX) ? FRAME_MAX : frame_width;
      hc = (frame_height > FRAME_MAX) ? FRAME_MAX : frame_height;
      lim_w = $signed({2'b00, wc}) - 15'sd1;
      lim_h = $signed({2'b00, hc}) - 15'sd1;
      clx = (tlx < 0) ? '0 : tlx;
      cly = (tly < 0) ? '0 : tly;
      chx = thx;
      chy = thy;
   end

   assign e1x = DW'(vx_ff[1]) - DW'(vx_ff[0]);
   assign e1y = DW'(vy_ff[1]) - DW'(vy_ff[0]);
   assign e2x = DW'(vx_ff[2]) - DW'(vx_ff[0]);
   assign e2y = DW'(vy_ff[2]) - DW'(vy_ff[0]);
   assign px  = $signed(DW'({1'b0, sx_ff} << COORD_FRAC_BITS)) - DW'(vx_ff[0]);
   assign py  = $signed(DW'({1'b0, sy_ff} << COORD_FRAC_BITS)) - DW'(vy_ff[0]);

   assign nv = SW'(p0_ff) - SW'(p1_ff);
   assign nw = SW'(p2_ff) - SW'(p3_ff);
   assign nu = d_ff - nv - nw;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= vx_in[i];
            vy_ff[i] <= vy_in[i];
         end
      end
      if (cmd.box) begin
         box_ok_ff <= (32'(clx) <= 32'(lim_w)) && (32'(cly) <= 32'(lim_h))
                      && (32'(clx) <= 32'(chx)) && (32'(cly) <= 32'(chy))
                      && (lim_w >= 0) && (lim_h >= 0);
         minx_ff <= PIX_W'(clx);
         miny_ff <= PIX_W'(cly);
         maxx_ff <= (32'(chx) > 32'(lim_w)) ? PIX_W'(lim_w) : PIX_W'(chx);
         maxy_ff <= (32'(chy) > 32'(lim_h)) ? PIX_W'(lim_h) : PIX_W'(chy);
         p0_ff <= PW'(e1x) * PW'(e2y);
         p1_ff <= PW'(e1y) * PW'(e2x);
      end
      if (cmd.area) d_ff <= SW'(p0_ff) - SW'(p1_ff);
      if (cmd.start) begin
         sx_ff <= minx_ff;
         sy_ff <= miny_ff;
      end
      if (cmd.mul) begin
         p0_ff <= PW'(px) * PW'(e2y);
         p1_ff <= PW'(py) * PW'(e2x);
         p2_ff <= PW'(e1x) * PW'(py);
         p3_ff <= PW'(e1y) * PW'(px);
      end
      if (cmd.test) begin
         if (d_ff > 0)      cov_ff <= (nv >= 0) && (nw >= 0) && (nu >= 0);
         else if (d_ff < 0) cov_ff <= (nv <= 0) && (nw <= 0) && (nu <= 0);
         else               cov_ff <= 1'b0;
      end
      if (cmd.step && !status.last) begin
         if (sx_ff == maxx_ff) begin
            sx_ff <= minx_ff;
            sy_ff <= sy_ff + 1'b1;
         end else begin
            sx_ff <= sx_ff + 1'b1;
         end
      end
   end

   assign status.box_ok  = box_ok_ff;
   assign status.area_ok = (d_ff != 0);
   assign status.last    = (sx_ff == maxx_ff) && (sy_ff == maxy_ff);
   assign rsp_pixel_x    = sx_ff;
   assign rsp_pixel_y    = sy_ff;
   assign rsp_covered    = cov_ff;
   assign rsp_last_pixel = status.last;
endmodule

// ===== rtl/triangle_rasterizer.sv =====
// triangle rasterizer: bounding box scan with edge sign coverage test
// usage:
// req channel carries a word with kind and three vertices (signed, 4 fraction bits)
// kind 0 loads a triangle, no response; degenerate or empty box stays idle
// kind 1 advances the scan by one pixel while a triangle is active, else nothing
// each advance gives one rsp word after the MUL and TEST states: position, covered, colour, last
// sequencer accepts one word at a time and takes no new word while one is in progress,
// so the pixel rate is set by the two registered multiply and sum steps of the coverage test
// rsp is held until rsp_ready; req_ready stays low meanwhile
// csr channel writes frame_width, frame_height, mesh_color; always ready
// frame size takes effect at next load, colour at once
// reset: no triangle loaded, registers 640, 480, 0x00ffffff
module triangle_rasterizer import trirast_pkg::*; #(
   parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic signed [15:0]   req_ax,
   input  logic signed [15:0]   req_ay,
   input  logic signed [15:0]   req_bx,
   input  logic signed [15:0]   req_by_coord,
   input  logic signed [15:0]   req_cx,
   input  logic signed [15:0]   req_cy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_pixel_x,
   output logic [PIX_W-1:0]     rsp_pixel_y,
   output logic                 rsp_covered,
   output logic [COLOR_W-1:0]   rsp_pixel_color,
   output logic                 rsp_last_pixel,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data
);
   cmd_type    cmd;
   status_type status;
   logic [FRAME_W-1:0] width_ff, height_ff;
   logic [COLOR_W-1:0] color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_W'(640);
         height_ff <= FRAME_W'(480);
         color_ff  <= 32'h00ff_ffff;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff  <= csr_data[FRAME_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_data[FRAME_W-1:0];
            CSR_MESH_COLOR:   color_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_pixel_color = color_ff;

   trirast_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_kind,
      .rsp_valid, .rsp_ready, .cmd, .status
   );

   trirast_datapath #(
      .COORD_INT_BITS(COORD_INT_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_dp (
      .clock, .cmd, .status, .req_ax, .req_ay, .req_bx, .req_by_coord,
      .req_cx, .req_cy, .frame_width(width_ff), .frame_height(height_ff),
      .rsp_pixel_x, .rsp_pixel_y, .rsp_covered, .rsp_last_pixel
   );
endmodule

// ===== dv/triangle_rasterizer_tb.sv =====
// testbench of the triangle rasterizer: directed and random words checked against a predictor
module triangle_rasterizer_tb;
   import trirast_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic               covered;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_word_type;

   localparam int WATCHDOG_LIMIT = 4000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic                 req_kind = 0;
   logic signed [15:0]   req_ax = 0, req_ay = 0, req_bx = 0;
   logic signed [15:0]   req_by_coord = 0, req_cx = 0, req_cy = 0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic [PIX_W-1:0]     rsp_pixel_x, rsp_pixel_y;
   logic                 rsp_covered, rsp_last_pixel;
   logic [COLOR_W-1:0]   rsp_pixel_color;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [COLOR_W-1:0]   csr_data = 0;

   triangle_rasterizer uut (.*);

   // predictor state
   logic [FRAME_W-1:0] frame_w = 13'd640, frame_h = 13'd480;
   logic [COLOR_W-1:0] colour = 32'h00ffffff;
   longint             vert [6];
   logic [PIX_W-1:0]   min_x, min_y, max_x, max_y, cur_x, cur_y;
   bit                 scanning = 0;

   pixel_word_type pixels_due [$];
   int  mismatches = 0;
   bit  quiet = 0;
   int  hold_len = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint trunc_px(longint s);
      return (s < 0) ? -((-s) >>> COORD_FRAC_BITS_DEF) : (s >>> COORD_FRAC_BITS_DEF);
   endfunction

   function automatic bit pixel_covered(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
      longint e1x, e1y, e2x, e2y, px, py, d, nv, nw, nu;
      e1x = vert[2] - vert[0];
      e1y = vert[3] - vert[1];
      e2x = vert[4] - vert[0];
      e2y = vert[5] - vert[1];
      px = (longint'(x) << COORD_FRAC_BITS_DEF) - vert[0];
      py = (longint'(y) << COORD_FRAC_BITS_DEF) - vert[1];
      d = e1x * e2y - e1y * e2x;
      nv = px * e2y - py * e2x;
      nw = e1x * py - e1y * px;
      nu = d - nv - nw;
      if (d > 0) return nv >= 0 && nw >= 0 && nu >= 0;
      if (d < 0) return nv <= 0 && nw <= 0 && nu <= 0;
      return 0;
   endfunction

   function automatic void load_triangle(logic signed [15:0] c [6]);
      longint lo_x, lo_y, hi_x, hi_y, w, h, d;
      for (int i = 0; i < 6; i++) vert[i] = c[i];
      scanning = 0;
      cur_x = 0;
      cur_y = 0;
      lo_x = trunc_px(vert[0] < vert[2] ? (vert[0] < vert[4] ? vert[0] : vert[4])
                                        : (vert[2] < vert[4] ? vert[2] : vert[4]));
      hi_x = trunc_px(vert[0] > vert[2] ? (vert[0] > vert[4] ? vert[0] : vert[4])
                                        : (vert[2] > vert[4] ? vert[2] : vert[4]));
      lo_y = trunc_px(vert[1] < vert[3] ? (vert[1] < vert[5] ? vert[1] : vert[5])
                                        : (vert[3] < vert[5] ? vert[3] : vert[5]));
      hi_y = trunc_px(vert[1] > vert[3] ? (vert[1] > vert[5] ? vert[1] : vert[5])
                                        : (vert[3] > vert[5] ? vert[3] : vert[5]));
      w = (frame_w > FRAME_MAX) ? FRAME_MAX : frame_w;
      h = (frame_h > FRAME_MAX) ? FRAME_MAX : frame_h;
      if (lo_x < 0) lo_x = 0;
      if (lo_y < 0) lo_y = 0;
      if (hi_x > w - 1) hi_x = w - 1;
      if (hi_y > h - 1) hi_y = h - 1;
      if (lo_x > hi_x || lo_y > hi_y) return;
      d = (vert[2] - vert[0]) * (vert[5] - vert[1]) - (vert[3] - vert[1]) * (vert[4] - vert[0]);
      if (d == 0) return;
      min_x = PIX_W'(lo_x);
      min_y = PIX_W'(lo_y);
      max_x = PIX_W'(hi_x);
      max_y = PIX_W'(hi_y);
      cur_x = min_x;
      cur_y = min_y;
      scanning = 1;
   endfunction

   function automatic void advance_scan();
      pixel_word_type p;
      if (!scanning) return;
      p.x = cur_x;
      p.y = cur_y;
      p.covered = pixel_covered(cur_x, cur_y);
      p.color = colour;
      p.last = (cur_x == max_x) && (cur_y == max_y);
      pixels_due = {pixels_due, p};
      if (p.last) scanning = 0;
      else if (cur_x == max_x) begin
         cur_x = min_x;
         cur_y = cur_y + 1'b1;
      end else cur_x = cur_x + 1'b1;
   endfunction

   task automatic send_word(bit kind, logic signed [15:0] c [6]);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_ax <= c[0];
      req_ay <= c[1];
      req_bx <= c[2];
      req_by_coord <= c[3];
      req_cx <= c[4];
      req_cy <= c[5];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind) advance_scan();
      else load_triangle(c);
   endtask

   task automatic load(int x0, int y0, int x1, int y1, int x2, int y2);
      logic signed [15:0] c [6];
      c = '{16'(x0), 16'(y0), 16'(x1), 16'(y1), 16'(x2), 16'(y2)};
      send_word(0, c);
   endtask

   task automatic step_scan(int n);
      logic signed [15:0] c [6];
      for (int i = 0; i < n; i++) begin
         foreach (c[k]) c[k] = 16'($urandom);
         send_word(1, c);
      end
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [COLOR_W-1:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_FRAME_WIDTH:  frame_w = value[FRAME_W-1:0];
         CSR_FRAME_HEIGHT: frame_h = value[FRAME_W-1:0];
         CSR_MESH_COLOR:   colour = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_basic_scan();
      step_scan(2);
      load(16, 16, 96, 24, 40, 88);
      step_scan(45);
      load(88, 40, 8, 8, 24, 72);
      step_scan(60);
      settle();
   endtask

   task automatic test_degenerate();
      load(16, 16, 48, 48, 80, 80);
      step_scan(3);
      load(32, 32, 32, 32, 32, 32);
      step_scan(3);
      load(-800, -900, -100, -50, -400, -16);
      step_scan(3);
      settle();
   endtask

   task automatic test_extremes();
      load(-32768, -32768, 32767, -32768, 0, 32767);
      step_scan(6);
      load(32767, 32767, -32768, 32767, -1, -32768);
      step_scan(4);
      load(-15, -15, 17, 0, 0, 17);
      step_scan(6);
      settle();
   endtask

   task automatic test_frame_limits();
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_FRAME_HEIGHT, 1);
      write_reg(CSR_MESH_COLOR, 32'h0);
      load(0, 0, 64, 0, 0, 64);
      step_scan(3);
      settle();
      write_reg(CSR_FRAME_WIDTH, 0);
      write_reg(CSR_MESH_COLOR, 32'hffffffff);
      load(0, 0, 64, 0, 0, 64);
      step_scan(2);
      settle();
      write_reg(CSR_FRAME_WIDTH, 8191);
      write_reg(CSR_FRAME_HEIGHT, 4096);
      load(65400, 65400, 65535, 65400, 65400, 65535);
      step_scan(4);
      load(32767, 32767, 32700, 32767, 32767, 32700);
      step_scan(12);
      settle();
   endtask

   task automatic test_backpressure();
      write_reg(CSR_FRAME_WIDTH, 640);
      write_reg(CSR_FRAME_HEIGHT, 480);
      quiet = 1;
      load(0, 0, 640, 0, 0, 640);
      hold_len = 300;
      step_scan(40);
      quiet = 0;
      settle();
   endtask

   task automatic random_triangle(int fw, int fh);
      int ox, oy;
      logic signed [15:0] c [6];
      if ($urandom_range(0, 9) == 0) begin
         foreach (c[k]) c[k] = 16'($urandom);
      end else begin
         ox = $urandom_range(0, fw + 2) * 16 - 32;
         oy = $urandom_range(0, fh + 2) * 16 - 32;
         for (int k = 0; k < 3; k++) begin
            c[2*k] = 16'(ox + $urandom_range(0, 160) - 16);
            c[2*k+1] = 16'(oy + $urandom_range(0, 160) - 16);
         end
      end
      send_word(0, c);
   endtask

   task automatic test_random();
      int fw, fh, sent;
      for (int phase = 0; phase < 6; phase++) begin
         fw = $urandom_range(1, 40);
         fh = $urandom_range(1, 40);
         if (phase == 5) begin
            fw = 4096;
            fh = 4096;
         end
         write_reg(CSR_FRAME_WIDTH, fw);
         write_reg(CSR_FRAME_HEIGHT, fh);
         write_reg(CSR_MESH_COLOR, $urandom);
         quiet = (phase == 2);
         sent = 0;
         while (sent < 180) begin
            random_triangle(fw < 40 ? fw : 40, fh < 40 ? fh : 40);
            sent++;
            for (int n = $urandom_range(1, 60); n > 0; n--) begin
               step_scan(1);
               sent++;
            end
         end
         quiet = 0;
         settle();
      end
   endtask

   // result side: random stalls, optional long hold, compare against due pixels
   initial begin
      int gap;
      pixel_word_type got, want;
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 19);
         if (hold_len > 0) begin
            gap = hold_len;
            hold_len = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 0;
            for (int i = 0; i < gap; i++) begin
               @(posedge clock);
            end
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = '{rsp_pixel_x, rsp_pixel_y, rsp_covered, rsp_pixel_color, rsp_last_pixel};
         if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %p", got);
         end else begin
            want = pixels_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** triangle_rasterizer: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_basic_scan();
      test_degenerate();
      test_extremes();
      test_frame_limits();
      test_backpressure();
      test_random();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pixels_due.size() == 0) begin
         $display("** triangle_rasterizer: PASSED **");
      end else begin
         $display("** triangle_rasterizer: FAILED **");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/trirast_pkg.sv
rtl/trirast_ctrl.sv
rtl/trirast_datapath.sv
rtl/triangle_rasterizer.sv
dv/triangle_rasterizer_tb.sv
